/* rtl/hrbp_pkg.sv */
// ----------------------------------------------------------------------------
// hrbp_pkg: shared types, character codes and lookups
// Character classes, header-name and encoding-word tables, and the result
// word passed from the parse core to the output stage.
// ----------------------------------------------------------------------------
package hrbp_pkg;

  // Status codes
  localparam logic [1:0] STATUS_MORE   = 2'd0;
  localparam logic [1:0] STATUS_ACCEPT = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  // Byte class codes
  localparam logic [1:0] CLASS_OTHER = 2'd0;
  localparam logic [1:0] CLASS_URI   = 2'd1;
  localparam logic [1:0] CLASS_REF   = 2'd2;
  localparam logic [1:0] CLASS_UA    = 2'd3;

  // Commit codes
  localparam logic [1:0] COMMIT_NONE = 2'd0;
  localparam logic [1:0] COMMIT_REF  = 2'd1;
  localparam logic [1:0] COMMIT_UA   = 2'd2;

  // Compression codes
  localparam logic [1:0] COMP_NONE    = 2'd0;
  localparam logic [1:0] COMP_DEFLATE = 2'd1;
  localparam logic [1:0] COMP_GZIP    = 2'd2;

  // Header match flag bits
  localparam int unsigned FLAG_AE  = 0;
  localparam int unsigned FLAG_REF = 1;
  localparam int unsigned FLAG_UA  = 2;

  // Found flag bits
  localparam int unsigned FOUND_DEFLATE = 0;
  localparam int unsigned FOUND_GZIP    = 1;

  // Name lengths
  localparam logic [3:0] LEN_AE  = 4'd15;
  localparam logic [3:0] LEN_REF = 4'd7;
  localparam logic [3:0] LEN_UA  = 4'd10;
  localparam logic [3:0] NAME_POS_MAX = 4'd15;

  // ASCII codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CTL_MAX = 8'h1F;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] byte_class;
    logic [7:0] byte_echo;
    logic [1:0] capture_commit;
    logic [1:0] compression;
  } result_t;

  function automatic logic is_ctl(logic [7:0] b);
    return (b <= CH_CTL_MAX) || (b == CH_DEL);
  endfunction

  function automatic logic is_sep(logic [7:0] b);
    logic r;
    case (b) inside
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_sep(b);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // "Accept-Encoding"
  function automatic logic [7:0] ae_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:  c = "A";
      4'd1:  c = "c";
      4'd2:  c = "c";
      4'd3:  c = "e";
      4'd4:  c = "p";
      4'd5:  c = "t";
      4'd6:  c = "-";
      4'd7:  c = "E";
      4'd8:  c = "n";
      4'd9:  c = "c";
      4'd10: c = "o";
      4'd11: c = "d";
      4'd12: c = "i";
      4'd13: c = "n";
      4'd14: c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "Referer"
  function automatic logic [7:0] ref_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "R";
      3'd1: c = "e";
      3'd2: c = "f";
      3'd3: c = "e";
      3'd4: c = "r";
      3'd5: c = "e";
      3'd6: c = "r";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "User-Agent"
  function automatic logic [7:0] ua_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = "U";
      4'd1: c = "s";
      4'd2: c = "e";
      4'd3: c = "r";
      4'd4: c = "-";
      4'd5: c = "A";
      4'd6: c = "g";
      4'd7: c = "e";
      4'd8: c = "n";
      4'd9: c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "deflate"
  function automatic logic [7:0] deflate_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "d";
      3'd1: c = "e";
      3'd2: c = "f";
      3'd3: c = "l";
      3'd4: c = "a";
      3'd5: c = "t";
      3'd6: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "gzip"
  function automatic logic [7:0] gzip_char(logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = "g";
      2'd1: c = "z";
      2'd2: c = "i";
      2'd3: c = "p";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Drop each name flag whose word no longer matches at this position
  function automatic logic [2:0] feed_flags(logic [2:0] flags, logic [3:0] pos,
                                            logic [7:0] b);
    logic [2:0] f;
    f = flags;
    if ((pos >= LEN_AE) || (ae_char(pos) != b))   f[FLAG_AE]  = 1'b0;
    if ((pos >= LEN_REF) || (ref_char(pos[2:0]) != b)) f[FLAG_REF] = 1'b0;
    if ((pos >= LEN_UA) || (ua_char(pos) != b))   f[FLAG_UA]  = 1'b0;
    return f;
  endfunction

  // Streaming matcher for "deflate": returns {hit, next progress}
  function automatic logic [3:0] deflate_step(logic [2:0] prog, logic [7:0] b);
    logic [3:0] n;
    logic       hit;
    if ((prog != 3'd7) && (deflate_char(prog) == b)) n = {1'b0, prog} + 4'd1;
    else n = (b == deflate_char(3'd0)) ? 4'd1 : 4'd0;
    hit = (n >= 4'd7);
    if (hit) n = 4'd0;
    return {hit, n[2:0]};
  endfunction

  // Streaming matcher for "gzip": returns {hit, next progress}
  function automatic logic [2:0] gzip_step(logic [1:0] prog, logic [7:0] b);
    logic [2:0] n;
    logic       hit;
    if (gzip_char(prog) == b) n = {1'b0, prog} + 3'd1;
    else n = (b == gzip_char(2'd0)) ? 3'd1 : 3'd0;
    hit = (n >= 3'd4);
    if (hit) n = 3'd0;
    return {hit, n[1:0]};
  endfunction

endpackage

/* rtl/hrbp_core.sv */
// ----------------------------------------------------------------------------
// hrbp_core: request parse state and per-byte step
// Holds the parser state and computes the result word for one byte; the
// state advances only when step_i is high.
// ----------------------------------------------------------------------------
module hrbp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             restart_i,
  output hrbp_pkg::result_t result_o
);

  typedef enum logic [4:0] {
    ST_METHOD_START, ST_METHOD, ST_URI, ST_VER_H, ST_VER_T1, ST_VER_T2,
    ST_VER_P, ST_VER_SLASH, ST_MAJOR_START, ST_MAJOR, ST_MINOR_START,
    ST_MINOR, ST_NL1, ST_LINE_START, ST_NAME, ST_SPACE, ST_VALUE, ST_NL2,
    ST_NL3
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] done_q, done_d;
  logic [3:0] pos_q, pos_d;
  logic [2:0] flags_q, flags_d;
  logic [2:0] dprog_q, dprog_d;
  logic [1:0] gprog_q, gprog_d;
  logic [1:0] found_q, found_d;
  logic [1:0] enc_q, enc_d;

  logic [1:0] cls, commit;
  logic       ok;
  logic [3:0] dstep;
  logic [2:0] gstep;
  logic [3:0] pos_inc;

  assign dstep   = hrbp_pkg::deflate_step(dprog_q, byte_i);
  assign gstep   = hrbp_pkg::gzip_step(gprog_q, byte_i);
  assign pos_inc = (pos_q < hrbp_pkg::NAME_POS_MAX) ? pos_q + 4'd1 : pos_q;

  // One parse step
  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    dprog_d = dprog_q;
    gprog_d = gprog_q;
    found_d = found_q;
    enc_d   = enc_q;
    cls     = hrbp_pkg::CLASS_OTHER;
    commit  = hrbp_pkg::COMMIT_NONE;
    ok      = 1'b1;
    if (done_q == hrbp_pkg::STATUS_MORE) begin
      case (state_q)
        ST_METHOD_START: begin
          if (hrbp_pkg::is_token(byte_i)) state_d = ST_METHOD;
          else ok = 1'b0;
        end
        ST_METHOD: begin
          if (byte_i == hrbp_pkg::CH_SP) state_d = ST_URI;
          else if (!hrbp_pkg::is_token(byte_i)) ok = 1'b0;
        end
        ST_URI: begin
          if (byte_i == hrbp_pkg::CH_SP) state_d = ST_VER_H;
          else if (hrbp_pkg::is_ctl(byte_i)) ok = 1'b0;
          else cls = hrbp_pkg::CLASS_URI;
        end
        ST_VER_H: begin
          if (byte_i == hrbp_pkg::CH_H) state_d = ST_VER_T1;
          else ok = 1'b0;
        end
        ST_VER_T1: begin
          if (byte_i == hrbp_pkg::CH_T) state_d = ST_VER_T2;
          else ok = 1'b0;
        end
        ST_VER_T2: begin
          if (byte_i == hrbp_pkg::CH_T) state_d = ST_VER_P;
          else ok = 1'b0;
        end
        ST_VER_P: begin
          if (byte_i == hrbp_pkg::CH_P) state_d = ST_VER_SLASH;
          else ok = 1'b0;
        end
        ST_VER_SLASH: begin
          if (byte_i == hrbp_pkg::CH_SLASH) state_d = ST_MAJOR_START;
          else ok = 1'b0;
        end
        ST_MAJOR_START: begin
          if (hrbp_pkg::is_digit(byte_i)) state_d = ST_MAJOR;
          else ok = 1'b0;
        end
        ST_MAJOR: begin
          if (byte_i == hrbp_pkg::CH_DOT) state_d = ST_MINOR_START;
          else if (!hrbp_pkg::is_digit(byte_i)) ok = 1'b0;
        end
        ST_MINOR_START: begin
          if (hrbp_pkg::is_digit(byte_i)) state_d = ST_MINOR;
          else ok = 1'b0;
        end
        ST_MINOR: begin
          if (byte_i == hrbp_pkg::CH_CR) state_d = ST_NL1;
          else if (!hrbp_pkg::is_digit(byte_i)) ok = 1'b0;
        end
        ST_NL1, ST_NL2: begin
          if (byte_i == hrbp_pkg::CH_LF) state_d = ST_LINE_START;
          else ok = 1'b0;
        end
        ST_LINE_START: begin
          // close the previous header line
          if (flags_q[hrbp_pkg::FLAG_AE]) begin
            if (found_q[hrbp_pkg::FOUND_GZIP]) enc_d = hrbp_pkg::COMP_GZIP;
            else if (found_q[hrbp_pkg::FOUND_DEFLATE]) enc_d = hrbp_pkg::COMP_DEFLATE;
          end
          if (flags_q[hrbp_pkg::FLAG_UA]) commit = hrbp_pkg::COMMIT_UA;
          else if (flags_q[hrbp_pkg::FLAG_REF]) commit = hrbp_pkg::COMMIT_REF;
          flags_d = 3'b000;
          if (byte_i == hrbp_pkg::CH_CR) begin
            state_d = ST_NL3;
          end else if (!hrbp_pkg::is_token(byte_i)) begin
            ok = 1'b0;
          end else begin
            state_d = ST_NAME;
            pos_d   = 4'd1;
            flags_d = hrbp_pkg::feed_flags(3'b111, 4'd0, byte_i);
            dprog_d = 3'd0;
            gprog_d = 2'd0;
            found_d = 2'b00;
          end
        end
        ST_NAME: begin
          if (byte_i == hrbp_pkg::CH_COLON) begin
            if (pos_q != hrbp_pkg::LEN_AE)  flags_d[hrbp_pkg::FLAG_AE]  = 1'b0;
            if (pos_q != hrbp_pkg::LEN_REF) flags_d[hrbp_pkg::FLAG_REF] = 1'b0;
            if (pos_q != hrbp_pkg::LEN_UA)  flags_d[hrbp_pkg::FLAG_UA]  = 1'b0;
            state_d = ST_SPACE;
          end else if (hrbp_pkg::is_token(byte_i)) begin
            flags_d = hrbp_pkg::feed_flags(flags_q, pos_q, byte_i);
            pos_d   = pos_inc;
          end else begin
            ok = 1'b0;
          end
        end
        ST_SPACE: begin
          if (byte_i == hrbp_pkg::CH_SP) state_d = ST_VALUE;
          else ok = 1'b0;
        end
        ST_VALUE: begin
          if (byte_i == hrbp_pkg::CH_CR) begin
            state_d = ST_NL2;
          end else if (hrbp_pkg::is_ctl(byte_i)) begin
            ok = 1'b0;
          end else begin
            if (flags_q[hrbp_pkg::FLAG_REF]) cls = hrbp_pkg::CLASS_REF;
            else if (flags_q[hrbp_pkg::FLAG_UA]) cls = hrbp_pkg::CLASS_UA;
            dprog_d = dstep[2:0];
            gprog_d = gstep[1:0];
            found_d = found_q | {gstep[2], dstep[3]};
          end
        end
        ST_NL3: begin
          done_d = (byte_i == hrbp_pkg::CH_LF) ? hrbp_pkg::STATUS_ACCEPT
                                                : hrbp_pkg::STATUS_REJECT;
        end
        default: ok = 1'b0;
      endcase
      if (!ok) done_d = hrbp_pkg::STATUS_REJECT;
    end
  end

  // Result word; restart gives all zero
  always_comb begin
    if (restart_i) begin
      result_o = '0;
    end else begin
      result_o.status         = done_d;
      result_o.byte_class     = cls;
      result_o.byte_echo      = byte_i;
      result_o.capture_commit = commit;
      result_o.compression    = enc_d;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_METHOD_START;
      done_q  <= hrbp_pkg::STATUS_MORE;
      pos_q   <= 4'd0;
      flags_q <= 3'b000;
      dprog_q <= 3'd0;
      gprog_q <= 2'd0;
      found_q <= 2'b00;
      enc_q   <= hrbp_pkg::COMP_NONE;
    end else if (step_i) begin
      if (restart_i) begin
        state_q <= ST_METHOD_START;
        done_q  <= hrbp_pkg::STATUS_MORE;
        pos_q   <= 4'd0;
        flags_q <= 3'b000;
        dprog_q <= 3'd0;
        gprog_q <= 2'd0;
        found_q <= 2'b00;
        enc_q   <= hrbp_pkg::COMP_NONE;
      end else begin
        state_q <= state_d;
        done_q  <= done_d;
        pos_q   <= pos_d;
        flags_q <= flags_d;
        dprog_q <= dprog_d;
        gprog_q <= gprog_d;
        found_q <= found_d;
        enc_q   <= enc_d;
      end
    end
  end

  // Finished status holds until restart
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q != hrbp_pkg::STATUS_MORE) && !(step_i && restart_i)
    |=> done_q == $past(done_q))
    else $error("finished status changed without restart");

  // Marked bytes only while the request is still open
  a_class_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.byte_class != hrbp_pkg::CLASS_OTHER) |->
    (done_q == hrbp_pkg::STATUS_MORE) && !restart_i)
    else $error("byte marked after request finished");

  // A commit only comes from the line-start step
  a_commit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.capture_commit != hrbp_pkg::COMMIT_NONE) |->
    (state_q == ST_LINE_START) && (done_q == hrbp_pkg::STATUS_MORE))
    else $error("commit outside line start");

  // Encoding choice stays a legal code
  a_enc_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_q != 2'd3)
    else $error("illegal compression choice");

endmodule

/* rtl/http_request_byte_parser.sv */
// ----------------------------------------------------------------------------
// http_request_byte_parser: HTTP/1.x request header checker
// Validates a request one byte per word and reports status, byte marks,
// header commits and the chosen content encoding for each byte.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one request byte per word in tdata, with tuser set to
//   restart the parser (that byte is ignored and its result is all zero).
//   Master side returns exactly one result word per input word, in order.
//   Each accepted byte passes the input register, then the parse step,
//   and its result is held in the result register. Throughput: one byte
//   per clock while the receiver takes each result; the parse step is a
//   single pass of logic between the two registers, so the loop through
//   the parser state holds no register but the state registers themselves.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; tready drops only once both are
//   full, and rises again in the cycle the receiver takes the result.
//   Reset clears both valid flags and returns the parser to method start
//   with no encoding chosen. A finished status (accepted or rejected)
//   stays on every later result until a restart word arrives.
// ----------------------------------------------------------------------------
module http_request_byte_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tuser_i,   // [0] restart
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [1:0] status, [9:2] byte_echo,
                                        // [11:10] capture_commit,
                                        // [13:12] compression, [15:14] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] byte_class
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_restart_q;
  logic              out_valid_q;
  hrbp_pkg::result_t out_q;
  hrbp_pkg::result_t step_res;
  logic              advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q    <= s_axis_tdata_i;
      in_restart_q <= s_axis_tuser_i;
    end
  end

  hrbp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .restart_i (in_restart_q),
    .result_o  (step_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.compression, out_q.capture_commit,
                            out_q.byte_echo, out_q.status};
  assign m_axis_tuser_o  = out_q.byte_class;

endmodule
